// ===== rtl/lps_pkg.sv =====
package lps_pkg;

    localparam int NUM_LEDS_DEF = 8;

    localparam int KIND_W    = 2;
    localparam int INDEX_W   = 3;
    localparam int OUT_W     = 8;
    localparam int PERIOD_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = PERIOD_W;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1000);

    localparam logic [CFG_IDX_W-1:0] REG_RUN_MODE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = CFG_IDX_W'(2);

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK    = 2'd0,
        KIND_TOGGLE  = 2'd1,
        KIND_RESTART = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        PAT_BOUNCE     = 2'd0,
        PAT_INVERT     = 2'd1,
        PAT_WALK_RIGHT = 2'd2,
        PAT_WALK_LEFT  = 2'd3
    } t_pattern;

endpackage

// ===== rtl/led_pattern_sequencer_top.sv =====
// A result is valid once its item has passed the input register and then the
// state update into the result register; an output stall can hold it in between.
// One item per cycle while the output is not stalled; the output register and the
// input register let a new item enter while a finished result waits to be taken.
// Reset (synchronous, active low) clears the LEDs, tick counter and valid
// flags, sets the bounce direction upward and loads register defaults.
module led_pattern_sequencer_top #(
    parameter int NUM_LEDS = lps_pkg::NUM_LEDS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lps_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lps_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [lps_pkg::KIND_W-1:0]    i_kind,
    input  logic [lps_pkg::INDEX_W-1:0]   i_led_index,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [lps_pkg::OUT_W-1:0]     o_led_values,
    output logic                          o_stepped
);
    import lps_pkg::*;

    localparam int N = NUM_LEDS;
    localparam logic [N-1:0] ONE_N = N'(1);

    // configuration
    logic                r_run_mode;
    t_pattern            r_pattern;
    logic [PERIOD_W-1:0] r_period;

    // input stage
    logic               r_in_valid;
    logic [KIND_W-1:0]  r_kind;
    logic [INDEX_W-1:0] r_index;

    // state
    logic [N-1:0]        r_levels;
    logic                r_moving_up;
    logic [PERIOD_W-1:0] r_tick_count;

    // result
    logic             r_out_valid;
    logic [OUT_W-1:0] r_led_values;
    logic             r_stepped;

    logic                n_levels;
    logic [N-1:0]        n_levels_v;
    logic                n_moving_up;
    logic [PERIOD_W-1:0] n_tick_count;
    logic                w_step;
    logic                w_advance;
    logic [PERIOD_W-1:0] w_count_inc;
    logic [N-1:0]        w_init;
    logic [N-1:0]        w_low;
    logic                w_up_bounce;
    logic [N-1:0]        w_pattern_next;
    logic [OUT_W-1:0]    w_out_bits;

    assign w_advance   = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_out_valid = r_out_valid;
    assign o_led_values = r_led_values;
    assign o_stepped   = r_stepped;

    // restart values per pattern
    genvar gi;
    generate
        for (gi = 0; gi < N; gi++) begin : g_init
            always_comb begin
                unique case (r_pattern)
                    PAT_BOUNCE: w_init[gi] = (gi == 0);
                    PAT_INVERT: w_init[gi] = ((gi % 2) == 1);
                    default:    w_init[gi] = ((gi % 3) == 0);
                endcase
            end
        end
        for (gi = 0; gi < OUT_W; gi++) begin : g_out
            if (gi < N) begin : g_bit
                assign w_out_bits[gi] = n_levels_v[gi];
            end else begin : g_zero
                assign w_out_bits[gi] = 1'b0;
            end
        end
    endgenerate

    // one pattern step; lowest lit LED isolated as a one-hot vector
    always_comb begin
        w_low = r_levels & (~r_levels + ONE_N);
        if (r_levels == '0) begin
            w_low = ONE_N;
        end
        if (w_low[0] && !r_moving_up) begin
            w_up_bounce = 1'b1;
        end else if (w_low[N-1] && r_moving_up) begin
            w_up_bounce = 1'b0;
        end else begin
            w_up_bounce = r_moving_up;
        end
        unique case (r_pattern)
            PAT_BOUNCE: begin
                if (N == 1) begin
                    w_pattern_next = ONE_N;
                end else if (w_up_bounce) begin
                    w_pattern_next = (r_levels & ~w_low) | (w_low << 1);
                end else begin
                    w_pattern_next = (r_levels & ~w_low) | (w_low >> 1);
                end
            end
            PAT_INVERT:     w_pattern_next = ~r_levels;
            PAT_WALK_RIGHT: w_pattern_next = (r_levels << 1) | (r_levels >> (N - 1));
            default:        w_pattern_next = (r_levels >> 1) | (r_levels << (N - 1));
        endcase
    end

    always_comb begin
        w_count_inc  = r_tick_count + PERIOD_W'(1);
        n_levels_v   = r_levels;
        n_moving_up  = r_moving_up;
        n_tick_count = r_tick_count;
        w_step       = 1'b0;
        n_levels     = 1'b0;
        case (r_kind)
            KIND_TICK: begin
                if (r_run_mode) begin
                    n_tick_count = w_count_inc;
                    if (w_count_inc >= r_period || w_count_inc == '0) begin
                        w_step       = 1'b1;
                        n_levels     = 1'b1;
                        n_levels_v   = w_pattern_next;
                        n_tick_count = '0;
                        if (r_pattern == PAT_BOUNCE) begin
                            n_moving_up = w_up_bounce;
                        end
                    end
                end
            end
            KIND_TOGGLE: begin
                if (32'(r_index) < N) begin
                    n_levels   = 1'b1;
                    n_levels_v = r_levels ^ (ONE_N << r_index);
                end
            end
            KIND_RESTART: begin
                n_levels     = 1'b1;
                n_levels_v   = w_init;
                n_tick_count = '0;
            end
            default: begin
                n_levels = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_mode <= 1'b0;
            r_pattern  <= PAT_BOUNCE;
            r_period   <= PERIOD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RUN_MODE: r_run_mode <= i_cfg_data[0];
                REG_PATTERN:  r_pattern  <= t_pattern'(i_cfg_data[1:0]);
                REG_PERIOD:   r_period   <= i_cfg_data[PERIOD_W-1:0];
                default:      r_run_mode <= r_run_mode;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_kind  <= i_kind;
            r_index <= i_led_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels     <= '0;
            r_moving_up  <= 1'b1;
            r_tick_count <= '0;
            r_out_valid  <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                if (n_levels) begin
                    r_levels <= n_levels_v;
                end
                r_moving_up  <= n_moving_up;
                r_tick_count <= n_tick_count;
            end
        end
        if (w_advance && r_in_valid) begin
            r_led_values <= w_out_bits;
            r_stepped    <= w_step;
        end
    end

    // a stepped result leaves the counter cleared until it is taken
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_stepped |-> r_tick_count == '0)
        else $error("stepped result with nonzero tick count");

    // bounce direction changes only on a processed step
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_moving_up != $past(r_moving_up)) |->
            $past(w_step && r_in_valid && w_advance))
        else $error("direction changed without a step");

    // a stalled output freezes the LED state
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> $stable(r_levels) && $stable(r_tick_count))
        else $error("state changed while output stalled");

endmodule
